// ===== sv/rbrm_pkg.sv =====
package rbrm_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int HOLD_BITS_DEF = 8;

    localparam int ACTION_W   = 3;
    localparam int HANDLE_W   = 6;
    localparam int NEED_W     = 7;
    localparam int LENGTH_W   = 16;
    localparam int COUNT_W    = 7;
    localparam int TOTAL_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TOTAL_W-1:0]   TOTAL_MAX        = '1;
    localparam logic [LENGTH_W-1:0]  BLOCK_LENGTH_RST = 16'd1;
    localparam logic [COUNT_W-1:0]   SLOTS_IN_USE_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 3'd0,
        ACT_REQUEST = 3'd1,
        ACT_AVAIL   = 3'd2,
        ACT_NEXT    = 3'd3,
        ACT_RELEASE = 3'd4,
        ACT_CLEAR   = 3'd5
    } act_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH,
        OP_CLEAR,
        OP_AVAIL,
        OP_REQ_RD,
        OP_REQ_WR,
        OP_NXT_RD,
        OP_NXT_MV,
        OP_NXT_WR,
        OP_REL_RD,
        OP_REL_WR,
        OP_WALK_RD,
        OP_WALK_STEP
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_REQ_WR,
        S_NXT_MV,
        S_NXT_WR,
        S_REL_WR,
        S_WALK_RD,
        S_WALK_CHK,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        act_t action;
        logic push_ok;
        logic req_ok;
        logic next_ok;
        logic in_ring;
        logic walk_more;
        logic head_free;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/rbrm_dp.sv =====
module rbrm_dp
    import rbrm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int HOLD_BITS = HOLD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ACTION_W-1:0]   action,
    input  logic [HANDLE_W-1:0]   handle,
    input  logic                  handle_valid,
    input  logic [NEED_W-1:0]     need_count,
    input  logic [LENGTH_W-1:0]   push_length,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  ok,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic                  handle_out_valid,
    output logic [COUNT_W-1:0]    filled_count,
    output logic [TOTAL_W-1:0]    total_holds,
    output logic [COUNT_W-1:0]    peak_filled,
    output logic [COUNT_W-1:0]    freed_count,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int FILL_W = $clog2(NUM_SLOTS + 1);
    localparam int CW     = ((FILL_W > NEED_W) ? FILL_W : NEED_W) + 1;
    localparam logic [CW-1:0]        N_C      = CW'(NUM_SLOTS);
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

    logic [LENGTH_W-1:0] blen_reg;
    logic [COUNT_W-1:0]  siu_reg;

    logic [ACTION_W-1:0] act_reg;
    logic [HANDLE_W-1:0] hdl_reg;
    logic                hv_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [LENGTH_W-1:0] plen_reg;

    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   ro_reg, ro_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [FILL_W-1:0]   peak_reg, peak_next;

    logic                ok_reg;
    logic [SLOT_W-1:0]   hout_reg;
    logic                houtv_reg;
    logic [FILL_W-1:0]   freed_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic                out_valid_reg;
    logic                o_ok_reg;
    logic [HANDLE_W-1:0] o_hout_reg;
    logic                o_houtv_reg;
    logic [COUNT_W-1:0]  o_fill_reg;
    logic [TOTAL_W-1:0]  o_total_reg;
    logic [COUNT_W-1:0]  o_peak_reg;
    logic [COUNT_W-1:0]  o_freed_reg;

    logic [HOLD_BITS-1:0] hold_mem [NUM_SLOTS];
    logic [HOLD_BITS-1:0] rd_data_reg;
    logic                 mem_we, mem_re;
    logic [SLOT_W-1:0]    wr_addr, rd_addr;
    logic [HOLD_BITS-1:0] wr_data;

    logic [CW-1:0] head_c, fill_c, ro_c, hdl_c, need_c, cap_c, dist_c;
    logic [SLOT_W-1:0] push_slot, req_slot, hdl_slot, nxt_slot;
    logic [HOLD_BITS-1:0] hold_inc, hold_dec;
    logic in_ring, avail_ok;

    function automatic logic [CW-1:0] wrap(input logic [CW-1:0] s);
        wrap = (s >= N_C) ? s - N_C : s;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg <= BLOCK_LENGTH_RST;
            siu_reg  <= SLOTS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_LENGTH: blen_reg <= cfg_data;
                REG_SLOTS_IN_USE: siu_reg  <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ring geometry
    always_comb
    begin
        head_c   = CW'(head_reg);
        fill_c   = CW'(fill_reg);
        ro_c     = CW'(ro_reg);
        hdl_c    = CW'(hdl_reg);
        need_c   = (need_reg == '0) ? CW'(1) : CW'(need_reg);
        cap_c    = (CW'(siu_reg) > N_C) ? N_C : CW'(siu_reg);
        dist_c   = (hdl_c >= head_c) ? hdl_c - head_c : hdl_c + N_C - head_c;
        in_ring  = hv_reg && (hdl_c < N_C) && (dist_c < fill_c);
        avail_ok = in_ring && ((fill_c - dist_c) >= need_c);
        push_slot = SLOT_W'(wrap(head_c + fill_c));
        req_slot  = SLOT_W'(wrap(head_c + fill_c - ro_c));
        hdl_slot  = SLOT_W'(hdl_c);
        nxt_slot  = SLOT_W'(wrap(hdl_c + CW'(1)));
        hold_inc  = (rd_data_reg != HOLD_MAX) ? rd_data_reg + 1'b1 : rd_data_reg;
        hold_dec  = (rd_data_reg != '0) ? rd_data_reg - 1'b1 : rd_data_reg;
    end

    always_comb
    begin
        stat.action    = act_t'(act_reg);
        stat.push_ok   = (plen_reg == blen_reg) && (fill_c < cap_c);
        stat.req_ok    = (ro_c != '0) && (ro_c <= fill_c) && (ro_c >= need_c);
        stat.next_ok   = in_ring && ((dist_c + CW'(1)) < fill_c);
        stat.in_ring   = in_ring;
        stat.walk_more = (fill_c != '0) && (ro_c != fill_c);
        stat.head_free = (rd_data_reg == '0);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // hold count memory ports
    always_comb
    begin
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = '0;
        rd_addr = '0;
        wr_data = '0;
        unique case (cmd.op)
            OP_PUSH:
            begin
                mem_we  = 1'b1;
                wr_addr = push_slot;
            end
            OP_REQ_RD:
            begin
                mem_re  = 1'b1;
                rd_addr = req_slot;
            end
            OP_REQ_WR:
            begin
                mem_we  = 1'b1;
                wr_addr = slot_reg;
                wr_data = hold_inc;
            end
            OP_NXT_RD, OP_REL_RD:
            begin
                mem_re  = 1'b1;
                rd_addr = hdl_slot;
            end
            OP_NXT_MV:
            begin
                mem_we  = 1'b1;
                wr_addr = hdl_slot;
                wr_data = hold_dec;
                mem_re  = 1'b1;
                rd_addr = nxt_slot;
            end
            OP_NXT_WR:
            begin
                mem_we  = 1'b1;
                wr_addr = nxt_slot;
                wr_data = hold_inc;
            end
            OP_REL_WR:
            begin
                mem_we  = 1'b1;
                wr_addr = hdl_slot;
                wr_data = hold_dec;
            end
            OP_WALK_RD:
            begin
                mem_re  = 1'b1;
                rd_addr = head_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hold_mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= hold_mem[rd_addr];
    end

    // ring state
    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        ro_next    = ro_reg;
        total_next = total_reg;
        peak_next  = peak_reg;
        unique case (cmd.op)
            OP_PUSH:
            begin
                fill_next = fill_reg + 1'b1;
                ro_next   = ro_reg + 1'b1;
                if (fill_next > peak_reg)
                    peak_next = fill_next;
            end
            OP_CLEAR:
            begin
                fill_next = '0;
                ro_next   = '0;
            end
            OP_REQ_WR:
            begin
                ro_next = ro_reg - 1'b1;
                if (total_reg != TOTAL_MAX)
                    total_next = total_reg + 1'b1;
            end
            OP_REL_WR:
            begin
                if (total_reg != '0)
                    total_next = total_reg - 1'b1;
            end
            OP_WALK_STEP:
            begin
                head_next = SLOT_W'(wrap(head_c + CW'(1)));
                fill_next = fill_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            fill_reg  <= '0;
            ro_reg    <= '0;
            total_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            ro_reg    <= ro_next;
            total_reg <= total_next;
            peak_reg  <= peak_next;
        end
    end

    // item and per-item result
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                act_reg   <= action;
                hdl_reg   <= handle;
                hv_reg    <= handle_valid;
                need_reg  <= need_count;
                plen_reg  <= push_length;
                ok_reg    <= 1'b0;
                hout_reg  <= '0;
                houtv_reg <= 1'b0;
                freed_reg <= '0;
            end
            OP_PUSH, OP_CLEAR, OP_REL_WR:
                ok_reg <= 1'b1;
            OP_AVAIL:
                ok_reg <= avail_ok;
            OP_REQ_RD:
                slot_reg <= req_slot;
            OP_REQ_WR:
            begin
                ok_reg    <= 1'b1;
                hout_reg  <= slot_reg;
                houtv_reg <= 1'b1;
            end
            OP_NXT_WR:
            begin
                ok_reg    <= 1'b1;
                hout_reg  <= nxt_slot;
                houtv_reg <= 1'b1;
            end
            OP_WALK_STEP:
                freed_reg <= freed_reg + 1'b1;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_ok_reg    <= ok_reg;
            o_hout_reg  <= HANDLE_W'(hout_reg);
            o_houtv_reg <= houtv_reg;
            o_fill_reg  <= COUNT_W'(fill_reg);
            o_total_reg <= total_reg;
            o_peak_reg  <= COUNT_W'(peak_reg);
            o_freed_reg <= COUNT_W'(freed_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign ok               = o_ok_reg;
    assign handle_out       = o_hout_reg;
    assign handle_out_valid = o_houtv_reg;
    assign filled_count     = o_fill_reg;
    assign total_holds      = o_total_reg;
    assign peak_filled      = o_peak_reg;
    assign freed_count      = o_freed_reg;

    a_marker_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ro_reg <= fill_reg)
        else $error("read marker beyond ring end");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill_reg) <= N_C)
        else $error("ring fill exceeds pool size");

    a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= fill_reg)
        else $error("peak below current fill");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_WALK_STEP |-> fill_reg != '0 && ro_reg != fill_reg)
        else $error("freed a slot from an empty ring or at the marker");

endmodule

// ===== sv/rbrm_ctrl.sv =====
module rbrm_ctrl
    import rbrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_OUT;
                case (stat.action)
                    ACT_PUSH:
                        if (stat.push_ok)
                            cmd.op = OP_PUSH;
                    ACT_REQUEST:
                        if (stat.req_ok)
                        begin
                            cmd.op     = OP_REQ_RD;
                            state_next = S_REQ_WR;
                        end
                    ACT_AVAIL:
                        cmd.op = OP_AVAIL;
                    ACT_NEXT:
                        if (stat.next_ok)
                        begin
                            cmd.op     = OP_NXT_RD;
                            state_next = S_NXT_MV;
                        end
                    ACT_RELEASE:
                        if (stat.in_ring)
                        begin
                            cmd.op     = OP_REL_RD;
                            state_next = S_REL_WR;
                        end
                        else
                            state_next = S_WALK_RD;
                    ACT_CLEAR:
                        cmd.op = OP_CLEAR;
                    default: ;
                endcase
            end
            S_REQ_WR:
            begin
                cmd.op     = OP_REQ_WR;
                state_next = S_OUT;
            end
            S_NXT_MV:
            begin
                cmd.op     = OP_NXT_MV;
                state_next = S_NXT_WR;
            end
            S_NXT_WR:
            begin
                cmd.op     = OP_NXT_WR;
                state_next = S_OUT;
            end
            S_REL_WR:
            begin
                cmd.op     = OP_REL_WR;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                if (stat.walk_more)
                begin
                    cmd.op     = OP_WALK_RD;
                    state_next = S_WALK_CHK;
                end
                else
                    state_next = S_OUT;
            end
            S_WALK_CHK:
            begin
                if (stat.head_free)
                begin
                    cmd.op     = OP_WALK_STEP;
                    state_next = S_WALK_RD;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |=> state_reg == S_DEC)
        else $error("item load did not enter decode");

    a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_WALK_STEP |-> $past(cmd.op) == OP_WALK_RD)
        else $error("walk step without a head read");

    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");

endmodule

// ===== sv/refcounted_block_ring_manager.sv =====
// Reference-counted block ring manager.
// Input channel (in_valid/in_stall) carries one action beat: push, request,
// available, next, release or clear, with handle, need count and push length.
// Output channel (out_valid/out_stall) returns exactly one result beat per
// action: ok, handle_out/handle_out_valid, filled/peak/freed counts and the
// running hold total.
// Steps from accept to result: push, available, clear and failed actions go
// from decode to the result register; request adds a hold-count write; next
// adds a move and a write; release adds a hold-count write if the handle is
// in the ring, then a head read and check per slot freed until a held head,
// an empty ring or the marker stops it. One action is worked at a time.
// Hold counts sit in a memory with a registered read port; every
// read-modify-write and every step of the freeing walk reads through it first.
// Reset empties the ring and zeroes the hold total and peak; the hold memory
// is not cleared, each slot's count is written by push before it is read.
// A stalled result sits in the output register; the next action is still
// accepted and worked, and waits for the register before its result is shown.
// Configuration writes (cfg_we) take effect at once and belong in idle time.
module refcounted_block_ring_manager
    import rbrm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int HOLD_BITS = HOLD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ACTION_W-1:0]   action,
    input  logic [HANDLE_W-1:0]   handle,
    input  logic                  handle_valid,
    input  logic [NEED_W-1:0]     need_count,
    input  logic [LENGTH_W-1:0]   push_length,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic                  handle_out_valid,
    output logic [COUNT_W-1:0]    filled_count,
    output logic [TOTAL_W-1:0]    total_holds,
    output logic [COUNT_W-1:0]    peak_filled,
    output logic [COUNT_W-1:0]    freed_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rbrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbrm_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .HOLD_BITS (HOLD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .action           (action),
        .handle           (handle),
        .handle_valid     (handle_valid),
        .need_count       (need_count),
        .push_length      (push_length),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .ok               (ok),
        .handle_out       (handle_out),
        .handle_out_valid (handle_out_valid),
        .filled_count     (filled_count),
        .total_holds      (total_holds),
        .peak_filled      (peak_filled),
        .freed_count      (freed_count),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
